### src/cvlp_pkg.sv
// Shared constants, register and command codes, and the raised-cosine table function.
package cvlp_pkg;

  localparam int ANGLE_W = 14;
  localparam int LIFT_W  = 13;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int DEN_W   = 15;

  localparam int CYCLE_UNITS      = 11520;
  localparam int HALF_CYCLE_UNITS = 5760;
  localparam logic [13:0] MIN_H2  = 14'd32;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] REG_CENTRE   = 2'd0;
  localparam logic [1:0] REG_DURATION = 2'd1;
  localparam logic [1:0] REG_PEAK     = 2'd2;
  localparam logic [1:0] REG_COUNT    = 2'd3;

  // sin^2 in Q16 from a Q30 angle; Taylor series to x^11, Horner form
  function automatic logic [16:0] rc_sin_sq(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] g;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    g  = (s * s) >> 44;
    return (g > 64'd65536) ? 17'd65536 : g[16:0];
  endfunction

endpackage

### src/cvlp_if.sv
// Valid/ready channel interfaces for input items and results.
interface cvlp_in_if;
  import cvlp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ANGLE_W-1:0]        crank_angle;
  logic [IDX_W-1:0]          sample_index;
  logic signed [ANGLE_W-1:0] sample_angle;
  logic [LIFT_W-1:0]         sample_lift;
  modport source (output valid, cmd, crank_angle, sample_index, sample_angle, sample_lift,
                  input ready);
  modport sink (input valid, cmd, crank_angle, sample_index, sample_angle, sample_lift,
                output ready);
endinterface

interface cvlp_out_if;
  import cvlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIFT_W-1:0] lift;
  logic              from_table;
  modport source (output valid, lift, from_table, input ready);
  modport sink (input valid, lift, from_table, output ready);
endinterface

### src/cvlp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module cvlp_div #(
  parameter int NW = 44,
  parameter int DW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### src/cvlp_ram.sv
// Profile sample store: one write port, one registered read port.
module cvlp_ram #(
  parameter int AW = 6,
  parameter int DW = 27
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### src/cam_valve_lift_profile.sv
// Top level: configuration registers, sequencer, shared multiplier and divider.
// A write item updates the table. A closed-valve evaluate item goes straight to a zero result;
// the cosine profile runs the divider, up to 31 wrap steps, table interpolation and rounding;
// the table profile scans up to m samples one entry a cycle and interpolates with the divider
// (NW = 31+clog2(depth+1), 40 by default). One item is handled at a time.
// Reset is asynchronous, active low; control and config registers reset; the table is not cleared.
module cam_valve_lift_profile #(
  parameter int MAX_SAMPLES        = 64,
  parameter int COSINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cvlp_in_if.sink     in_i,
  cvlp_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cvlp_pkg::*;

  localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int MW = $clog2(MAX_SAMPLES + 1);
  localparam int TW = $clog2(COSINE_TABLE_DEPTH + 1);
  localparam int IW = $clog2(COSINE_TABLE_DEPTH);
  localparam int NW = 15 + TW + 16;
  localparam logic [NW-1:0] PERIOD = NW'(COSINE_TABLE_DEPTH) << 16;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_CDIV  = 4'd2;
  localparam logic [3:0] S_CMOD  = 4'd3;
  localparam logic [3:0] S_CTAB  = 4'd4;
  localparam logic [3:0] S_CG    = 4'd5;
  localparam logic [3:0] S_CRND  = 4'd6;
  localparam logic [3:0] S_T0    = 4'd7;
  localparam logic [3:0] S_TL    = 4'd8;
  localparam logic [3:0] S_TSCAN = 4'd9;
  localparam logic [3:0] S_TM1   = 4'd10;
  localparam logic [3:0] S_TM2   = 4'd11;
  localparam logic [3:0] S_TM3   = 4'd12;
  localparam logic [3:0] S_TDIV  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // configuration
  logic [13:0]      centre_q;
  logic [13:0]      dur_q;
  logic [12:0]      peak_q;
  logic [CNT_W-1:0] count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      dur_q    <= 14'd4096;
      peak_q   <= 13'd2560;
      count_q  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CENTRE:   centre_q <= pwdata[13:0];
        REG_DURATION: dur_q    <= pwdata[13:0];
        REG_PEAK:     peak_q   <= pwdata[12:0];
        REG_COUNT:    count_q  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTRE:   prdata = 32'(centre_q);
      REG_DURATION: prdata = 32'(dur_q);
      REG_PEAK:     prdata = 32'(peak_q);
      REG_COUNT:    prdata = 32'(count_q);
      default:      prdata = '0;
    endcase
  end

  // raised-cosine table, constant after elaboration
  logic [16:0] rc_tab [COSINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= COSINE_TABLE_DEPTH; k++) begin : g_rc
    localparam logic [63:0] KK = (2 * k > COSINE_TABLE_DEPTH) ?
                                 64'(COSINE_TABLE_DEPTH - k) : 64'(k);
    localparam logic [63:0] XX = (KK * PI_Q30) / COSINE_TABLE_DEPTH;
    assign rc_tab[k] = rc_sin_sq(XX);
  end

  // state
  logic [3:0]  state_q, state_d;
  logic        out_valid_q;
  logic        in_acc;

  logic signed [15:0] w_q;
  logic [NW-1:0]      pos_q;
  logic [16:0]        ga_q;
  logic               gneg_q;
  logic [33:0]        mul_q;
  logic [27:0]        acc_q;
  logic signed [13:0] prev_a_q;
  logic [12:0]        prev_l_q;
  logic [12:0]        l1_q;
  logic [14:0]        span_q;
  logic [14:0]        dc_q;
  logic [AW-1:0]      i_q;
  logic [12:0]        res_lift_q;
  logic               res_tab_q;
  logic [12:0]        out_lift_q;
  logic               out_tab_q;

  // datapath helpers
  logic signed [15:0] diff;
  logic signed [15:0] w_wrap;
  logic [15:0]        aw;
  logic [13:0]        h2;
  logic               open;
  logic [MW-1:0]      m;
  logic signed [17:0] cnum_s;
  logic [13:0]        dsafe;
  logic [TW-1:0]      idx_a;
  logic [TW-1:0]      idx_b;
  logic [16:0]        tab_a;
  logic [16:0]        tab_b;
  logic [16:0]        g;
  logic [30:0]        rnd;
  logic [14:0]        rval;

  logic [26:0]        rdata;
  logic signed [13:0] r_ang;
  logic [12:0]        r_lift;
  logic signed [16:0] w_x;
  logic signed [16:0] span_s;
  logic signed [16:0] d_s;
  logic [14:0]        dc;
  logic [AW-1:0]      raddr;
  logic               ram_we;

  logic [16:0]        mul_a;
  logic [16:0]        mul_b;
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NW-1:0]      div_quo;

  function automatic logic [12:0] clamp_pk(input logic [NW-1:0] v, input logic [12:0] pk);
    return (v > NW'(pk)) ? pk : v[12:0];
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign ram_we     = in_acc && (in_i.cmd == CMD_WRITE) && (32'(in_i.sample_index) < MAX_SAMPLES);

  assign diff   = $signed({2'b0, in_i.crank_angle}) - $signed({2'b0, centre_q});
  assign w_wrap = (diff > 16'(HALF_CYCLE_UNITS))  ? diff - 16'(CYCLE_UNITS) :
                  (diff < -16'(HALF_CYCLE_UNITS)) ? diff + 16'(CYCLE_UNITS) : diff;

  assign aw     = w_q[15] ? 16'(-w_q) : 16'(w_q);
  assign h2     = (dur_q > MIN_H2) ? dur_q : MIN_H2;
  assign open   = {aw, 1'b0} < 17'(h2);
  assign m      = (32'(count_q) > MAX_SAMPLES) ? MW'(MAX_SAMPLES) : MW'(count_q);
  assign cnum_s = 18'(w_q) + 18'(w_q) + $signed({4'b0, h2});
  assign dsafe  = (dur_q == '0) ? 14'd1 : dur_q;

  assign idx_a = TW'(pos_q[16 +: IW]);
  assign idx_b = idx_a + 1'b1;
  assign tab_a = rc_tab[idx_a];
  assign tab_b = rc_tab[idx_b];
  assign g     = gneg_q ? ga_q - mul_q[32:16] : ga_q + mul_q[32:16];
  assign rnd   = 31'(mul_q[29:0]) + 31'd32768;
  assign rval  = rnd[30:16];

  assign r_ang  = $signed(rdata[26:13]);
  assign r_lift = rdata[12:0];
  assign w_x    = 17'(w_q);
  assign span_s = 17'(r_ang) - 17'(prev_a_q);
  assign d_s    = w_x - 17'(prev_a_q);
  assign dc     = (d_s < 0) ? 15'd0 : (d_s > span_s) ? span_s[14:0] : d_s[14:0];

  always_comb begin
    state_d   = state_q;
    raddr     = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.cmd == CMD_EVAL) state_d = S_CLASS;
      end
      S_CLASS: begin
        if (!open) begin
          state_d = S_DONE;
        end else if (m < MW'(2)) begin
          div_start = 1'b1;
          div_num   = (NW'(cnum_s[14:0]) * NW'(COSINE_TABLE_DEPTH)) << 16;
          div_den   = {dsafe, 1'b0};
          state_d   = S_CDIV;
        end else begin
          state_d = S_T0;
        end
      end
      S_CDIV: if (div_done) state_d = S_CMOD;
      S_CMOD: if (pos_q < PERIOD) state_d = S_CTAB;
      S_CTAB: begin
        mul_a   = (tab_b < tab_a) ? tab_a - tab_b : tab_b - tab_a;
        mul_b   = 17'(pos_q[15:0]);
        state_d = S_CG;
      end
      S_CG: begin
        mul_a   = 17'(peak_q);
        mul_b   = g;
        state_d = S_CRND;
      end
      S_CRND: state_d = S_DONE;
      S_T0: begin
        raddr = AW'(m - 1'b1);
        if (17'(r_ang) >= w_x) state_d = S_DONE;
        else                   state_d = S_TL;
      end
      S_TL: begin
        raddr = AW'(1);
        if (w_x >= 17'(r_ang)) state_d = S_DONE;
        else                   state_d = S_TSCAN;
      end
      S_TSCAN: begin
        raddr = i_q + 1'b1;
        if (w_x <= 17'(r_ang)) begin
          state_d = (span_s <= 0) ? S_DONE : S_TM1;
        end else if (MW'(i_q) >= m - 1'b1) begin
          state_d = S_DONE;
        end
      end
      S_TM1: begin
        mul_a   = 17'(prev_l_q);
        mul_b   = 17'(span_q - dc_q);
        state_d = S_TM2;
      end
      S_TM2: begin
        mul_a   = 17'(l1_q);
        mul_b   = 17'(dc_q);
        state_d = S_TM3;
      end
      S_TM3: begin
        div_start = 1'b1;
        div_num   = NW'(30'(acc_q) + 30'(mul_q[27:0]) + 30'(span_q >> 1));
        div_den   = span_q;
        state_d   = S_TDIV;
      end
      S_TDIV: if (div_done) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_o.ready)                                  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        w_q <= w_wrap;
      end
      S_CLASS: begin
        res_lift_q <= '0;
        res_tab_q  <= 1'b0;
      end
      S_CDIV: begin
        if (div_done) pos_q <= div_quo;
      end
      S_CMOD: begin
        if (pos_q >= PERIOD) pos_q <= pos_q - PERIOD;
      end
      S_CTAB: begin
        ga_q   <= tab_a;
        gneg_q <= tab_b < tab_a;
      end
      S_CRND: begin
        res_lift_q <= clamp_pk(NW'(rval), peak_q);
      end
      S_T0: begin
        prev_a_q   <= r_ang;
        prev_l_q   <= r_lift;
        res_tab_q  <= 1'b1;
        res_lift_q <= clamp_pk(NW'(r_lift), peak_q);
      end
      S_TL: begin
        i_q        <= AW'(1);
        res_lift_q <= clamp_pk(NW'(r_lift), peak_q);
      end
      S_TSCAN: begin
        if (w_x <= 17'(r_ang)) begin
          span_q     <= span_s[14:0];
          dc_q       <= dc;
          l1_q       <= r_lift;
          res_lift_q <= clamp_pk(NW'((d_s > 0) ? r_lift : prev_l_q), peak_q);
        end else begin
          prev_a_q   <= r_ang;
          prev_l_q   <= r_lift;
          i_q        <= i_q + 1'b1;
          res_lift_q <= '0;
        end
      end
      S_TM2: begin
        acc_q <= mul_q[27:0];
      end
      S_TDIV: begin
        if (div_done) res_lift_q <= clamp_pk(div_quo, peak_q);
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_lift_q <= res_lift_q;
          out_tab_q  <= res_tab_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.lift       = out_lift_q;
  assign out_o.from_table = out_tab_q;

  cvlp_ram #(
    .AW(AW),
    .DW(ANGLE_W + LIFT_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_i.sample_index)),
    .wdata_i({in_i.sample_angle, in_i.sample_lift}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  cvlp_div #(
    .NW(NW),
    .DW(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );
endmodule

### src/cvlp_chk.sv
// Port-level checks for the lift profile block, bound to the top level.
module cvlp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] out_lift_i,
  input logic        out_tab_i
);
  import cvlp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_lift_i) && $stable(out_tab_i))
    else $error("result changed while stalled");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == CMD_EVAL |=> !in_ready_i)
    else $error("evaluate transfer did not make the block busy");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == CMD_WRITE && !out_valid_i |=> !out_valid_i)
    else $error("write transfer produced a result");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared with no evaluation in progress");
endmodule

bind cam_valve_lift_profile cvlp_chk u_cvlp_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_cmd_i   (in_i.cmd),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_lift_i (out_o.lift),
  .out_tab_i  (out_o.from_table)
);
